@@ rtl/jrb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrb_pkg: shared types and constants of the jitter reorder buffer
// Depth, field widths, opcodes, register indexes and controller interface.
// ----------------------------------------------------------------------------
package jrb_pkg;

    localparam int DEPTH            = 64;
    localparam int AW               = $clog2(DEPTH);
    localparam int CW               = $clog2(DEPTH + 1);
    localparam int MIN_LENGTH       = 12;
    localparam int NS_PER_MS        = 1000000;
    localparam int FAST_DELAY_MS    = 8;
    localparam int STABLE_THRESHOLD = 2;
    localparam int DELAY_W          = 14;
    localparam int SCALE_W          = 21;
    localparam int LIMIT_W          = DELAY_W + SCALE_W;
    localparam logic [SCALE_W-1:0] SPAN_SCALE = SCALE_W'(2 * NS_PER_MS);

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_POP = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LATENCY = 2'd1;

    typedef struct packed {
        logic [15:0] seq;
        logic [63:0] stamp;
        logic [15:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        RD_POS_M1,
        RD_FRONT,
        RD_BACK,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_START,
        ST_INS_TEST,
        ST_INS_CMP,
        ST_POP_RD,
        ST_POP_CAP,
        ST_SPAN_START,
        ST_CAP_BACK,
        ST_CAP_FRONT,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    add_start;
        logic    pos_init;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_shift;
        logic    wr_new;
        logic    cap_back;
        logic    cap_front;
        logic    drop_front;
        logic    pop_take;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic add_req;
        logic short_in;
        logic pop_ok;
        logic add_ok;
        logic pos_zero;
        logic seq_after;
        logic count_ge2;
        logic count_gt2;
        logic stale;
        logic out_busy;
    } status_t;

endpackage

@@ rtl/jrb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/jrb_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrb_datapath: entry store, pointers, counters and result registers
// Circular entry RAM addressed from a head pointer, plus span arithmetic.
// ----------------------------------------------------------------------------
module jrb_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  jrb_pkg::cmd_t                     cmd,
    output jrb_pkg::status_t                  status,
    input  logic                              cfg_valid,
    input  logic [jrb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jrb_pkg::DELAY_W-1:0]       cfg_data,
    input  logic                              opcode,
    input  logic [15:0]                       packet_ref,
    input  logic [15:0]                       packet_length,
    input  logic [15:0]                       sequence_req,
    input  logic [63:0]                       arrival_time,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              popped,
    output logic [15:0]                       out_ref,
    output logic [15:0]                       out_sequence,
    output logic [63:0]                       out_time,
    output logic                              add_ignored,
    output logic [6:0]                        fill_count,
    output logic [63:0]                       fill_span_ns,
    output logic [31:0]                       received_count,
    output logic [31:0]                       dropped_count
);

    localparam int AW = jrb_pkg::AW;
    localparam int CW = jrb_pkg::CW;

    // configuration
    logic [jrb_pkg::DELAY_W-1:0] delay_reg;
    logic                        low_lat_reg;
    logic [jrb_pkg::LIMIT_W-1:0] limit_reg;

    // control state
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] pos_reg;
    logic [31:0]   recv_reg;
    logic [31:0]   drop_reg;
    logic          out_valid_reg;

    // item and work payload
    logic                op_reg;
    logic                short_reg;
    jrb_pkg::entry_t     new_reg;
    logic [63:0]         back_reg;
    logic [63:0]         diff_reg;
    logic                res_popped_reg;
    jrb_pkg::entry_t     res_reg;

    // result payload
    logic                popped_reg;
    logic [15:0]         out_ref_reg;
    logic [15:0]         out_seq_reg;
    logic [63:0]         out_time_reg;
    logic                ignored_reg;
    logic [6:0]          fill_reg;
    logic [63:0]         span_reg;
    logic [31:0]         recv_out_reg;
    logic [31:0]         drop_out_reg;

    // RAM
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    jrb_pkg::entry_t ram_wdata;
    logic [AW-1:0]   ram_raddr;
    jrb_pkg::entry_t ram_rdata;
    logic [AW-1:0]   rd_logical;
    logic [AW-1:0]   head_inc;
    logic [15:0]     seq_diff;
    logic            fast_pop;
    logic [CW-1:0]   count_after_full;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
        logic [AW:0] sum;
        begin
            sum = {1'b0, h} + {1'b0, l};
            if (sum >= (AW + 1)'(jrb_pkg::DEPTH))
            begin
                sum = sum - (AW + 1)'(jrb_pkg::DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    assign head_inc = (head_reg == AW'(jrb_pkg::DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            jrb_pkg::RD_POS_M1: rd_logical = pos_reg - 1'b1;
            jrb_pkg::RD_BACK:   rd_logical = AW'(count_reg - 1'b1);
            jrb_pkg::RD_NEXT:   rd_logical = AW'(1);
            default:            rd_logical = '0;
        endcase
    end

    assign ram_raddr = phys(head_reg, rd_logical);
    assign ram_we    = cmd.wr_shift | cmd.wr_new;
    assign ram_waddr = phys(head_reg, pos_reg);
    assign ram_wdata = cmd.wr_new ? new_reg : ram_rdata;

    jrb_ram #(
        .WIDTH (jrb_pkg::ENTRY_W),
        .DEPTH (jrb_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // status toward the controller
    assign seq_diff = new_reg.seq - ram_rdata.seq;
    assign fast_pop = low_lat_reg || (delay_reg <= jrb_pkg::DELAY_W'(jrb_pkg::FAST_DELAY_MS));

    always_comb
    begin
        status.add_req   = (opcode == jrb_pkg::OP_ADD);
        status.short_in  = (packet_length < 16'(jrb_pkg::MIN_LENGTH));
        status.pop_ok    = fast_pop ? (count_reg != '0)
                                    : (count_reg >= CW'(jrb_pkg::STABLE_THRESHOLD));
        status.add_ok    = (op_reg == jrb_pkg::OP_ADD) && !short_reg;
        status.pos_zero  = (pos_reg == '0);
        status.seq_after = (seq_diff != 16'd0) && !seq_diff[15];
        status.count_ge2 = (count_reg >= CW'(2));
        status.count_gt2 = (count_reg > CW'(2));
        status.stale     = (diff_reg > {{(64 - jrb_pkg::LIMIT_W){1'b0}}, limit_reg});
        status.out_busy  = out_valid_reg && !out_ready;
    end

    // occupancy once a full buffer has given up its front entry
    assign count_after_full = (count_reg == CW'(jrb_pkg::DEPTH)) ? count_reg - 1'b1 : count_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= jrb_pkg::DELAY_W'(50);
            low_lat_reg   <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            recv_reg      <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    jrb_pkg::CFG_MAX_DELAY:   delay_reg   <= cfg_data;
                    jrb_pkg::CFG_LOW_LATENCY: low_lat_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.add_start)
            begin
                recv_reg <= recv_reg + 1'b1;
                if (count_reg == CW'(jrb_pkg::DEPTH))
                begin
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                    drop_reg  <= drop_reg + 1'b1;
                end
            end
            if (cmd.pos_init)
            begin
                pos_reg <= AW'(count_after_full);
            end
            if (cmd.wr_shift)
            begin
                pos_reg <= pos_reg - 1'b1;
            end
            if (cmd.wr_new)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.drop_front)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
                drop_reg  <= drop_reg + 1'b1;
            end
            if (cmd.pop_take)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        limit_reg <= jrb_pkg::LIMIT_W'(delay_reg) * jrb_pkg::LIMIT_W'(jrb_pkg::SPAN_SCALE);
        if (cmd.load_in)
        begin
            op_reg         <= opcode;
            short_reg      <= (packet_length < 16'(jrb_pkg::MIN_LENGTH));
            new_reg.seq    <= sequence_req;
            new_reg.stamp  <= arrival_time;
            new_reg.tag    <= packet_ref;
            res_popped_reg <= 1'b0;
            res_reg        <= '0;
        end
        if (cmd.pop_take)
        begin
            res_popped_reg <= 1'b1;
            res_reg        <= ram_rdata;
        end
        if (cmd.cap_back)
        begin
            back_reg <= ram_rdata.stamp;
        end
        if (cmd.cap_front)
        begin
            diff_reg <= back_reg - ram_rdata.stamp;
        end
        if (cmd.out_load)
        begin
            popped_reg   <= res_popped_reg;
            out_ref_reg  <= res_reg.tag;
            out_seq_reg  <= res_reg.seq;
            out_time_reg <= res_reg.stamp;
            ignored_reg  <= (op_reg == jrb_pkg::OP_ADD) && short_reg;
            fill_reg     <= 7'(count_reg);
            span_reg     <= (count_reg >= CW'(2)) ? diff_reg : 64'd0;
            recv_out_reg <= recv_reg;
            drop_out_reg <= drop_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign popped         = popped_reg;
    assign out_ref        = out_ref_reg;
    assign out_sequence   = out_seq_reg;
    assign out_time       = out_time_reg;
    assign add_ignored    = ignored_reg;
    assign fill_count     = fill_reg;
    assign fill_span_ns   = span_reg;
    assign received_count = recv_out_reg;
    assign dropped_count  = drop_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(jrb_pkg::DEPTH))
        else $error("occupancy above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow occupancy");

    a_drop_keeps_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_front |-> count_reg > CW'(1))
        else $error("stale drop with one entry left");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

@@ rtl/jrb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrb_ctrl: sequencer of the jitter reorder buffer
// Steps insert walk, pop, stale-drop scan and result hand-off.
// ----------------------------------------------------------------------------
module jrb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  jrb_pkg::status_t status,
    output jrb_pkg::cmd_t    cmd
);

    jrb_pkg::state_t state_reg;
    jrb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jrb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.add_req)
                    begin
                        state_next = status.short_in ? jrb_pkg::ST_SPAN_START
                                                     : jrb_pkg::ST_ADD_START;
                    end
                    else
                    begin
                        state_next = status.pop_ok ? jrb_pkg::ST_POP_RD
                                                   : jrb_pkg::ST_SPAN_START;
                    end
                end
            end
            jrb_pkg::ST_ADD_START: state_next = jrb_pkg::ST_INS_TEST;
            jrb_pkg::ST_INS_TEST:
            begin
                state_next = status.pos_zero ? jrb_pkg::ST_SPAN_START : jrb_pkg::ST_INS_CMP;
            end
            jrb_pkg::ST_INS_CMP:
            begin
                state_next = status.seq_after ? jrb_pkg::ST_SPAN_START : jrb_pkg::ST_INS_TEST;
            end
            jrb_pkg::ST_POP_RD:  state_next = jrb_pkg::ST_POP_CAP;
            jrb_pkg::ST_POP_CAP: state_next = jrb_pkg::ST_SPAN_START;
            jrb_pkg::ST_SPAN_START:
            begin
                state_next = status.count_ge2 ? jrb_pkg::ST_CAP_BACK : jrb_pkg::ST_DONE;
            end
            jrb_pkg::ST_CAP_BACK:  state_next = jrb_pkg::ST_CAP_FRONT;
            jrb_pkg::ST_CAP_FRONT: state_next = jrb_pkg::ST_CHECK;
            jrb_pkg::ST_CHECK:
            begin
                if (status.add_ok && status.stale && status.count_gt2)
                begin
                    state_next = jrb_pkg::ST_CAP_FRONT;
                end
                else
                begin
                    state_next = jrb_pkg::ST_DONE;
                end
            end
            jrb_pkg::ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = jrb_pkg::ST_IDLE;
                end
            end
            default: state_next = jrb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.rd_sel = jrb_pkg::RD_FRONT;
        in_ready = 1'b0;
        unique case (state_reg)
            jrb_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            jrb_pkg::ST_ADD_START:
            begin
                cmd.add_start = 1'b1;
                cmd.pos_init  = 1'b1;
            end
            jrb_pkg::ST_INS_TEST:
            begin
                if (status.pos_zero)
                begin
                    cmd.wr_new = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = jrb_pkg::RD_POS_M1;
                end
            end
            jrb_pkg::ST_INS_CMP:
            begin
                cmd.wr_new   = status.seq_after;
                cmd.wr_shift = !status.seq_after;
            end
            jrb_pkg::ST_POP_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            jrb_pkg::ST_POP_CAP:
            begin
                cmd.pop_take = 1'b1;
            end
            jrb_pkg::ST_SPAN_START:
            begin
                cmd.rd_en  = status.count_ge2;
                cmd.rd_sel = jrb_pkg::RD_BACK;
            end
            jrb_pkg::ST_CAP_BACK:
            begin
                cmd.cap_back = 1'b1;
                cmd.rd_en    = 1'b1;
            end
            jrb_pkg::ST_CAP_FRONT:
            begin
                cmd.cap_front = 1'b1;
            end
            jrb_pkg::ST_CHECK:
            begin
                if (status.add_ok && status.stale)
                begin
                    // head advances on this edge, so fetch the entry behind it
                    cmd.drop_front = 1'b1;
                    cmd.rd_en      = status.count_gt2;
                    cmd.rd_sel     = jrb_pkg::RD_NEXT;
                end
            end
            jrb_pkg::ST_DONE:
            begin
                cmd.out_load = !status.out_busy;
            end
            default: ;
        endcase
    end

    // pos is loaded in the cycle before the first insert test
    assign_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jrb_pkg::ST_ADD_START) |=> (state_reg == jrb_pkg::ST_INS_TEST))
        else $error("insert walk did not start");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == jrb_pkg::ST_IDLE))
        else $error("result loaded without return to idle");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> !in_ready)
        else $error("second item taken while working");

endmodule

@@ rtl/rtp_jitter_reorder_buffer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_jitter_reorder_buffer_unit: sequence-ordered RTP descriptor buffer
// Top level joining the sequencer and the entry datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per command: an add
//   (opcode 0) inserts a descriptor in wrap-around sequence order and drops
//   stale front entries; a pop (opcode 1) releases the front entry once the
//   threshold of one or two entries is met.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   input beat: released entry, occupancy, span and running counters.
//   Config channel (cfg_valid/cfg_ready) writes the jitter delay in ms
//   (index 0) and low_latency (index 1); it is always ready, write only idle.
//   One command at a time. A releasing pop reads the front entry, then takes
//   it; an ignored add or a pop below its threshold goes straight to the span
//   check, which is skipped below two entries; an add walks from the back,
//   moving one entry per step, then drops stale front entries. The entry RAM,
//   with one write and one read port, is read and written once per walk step.
//   The next beat is accepted once the result is in the output register, even
//   while it waits for out_ready; a stalled receiver holds the block in its
//   final step. Reset clears occupancy, counters and control registers
//   (delay 50 ms, normal latency). Entry storage needs no clearing pass.
// ----------------------------------------------------------------------------
module rtp_jitter_reorder_buffer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jrb_pkg::DELAY_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [15:0]                   packet_ref,
    input  logic [15:0]                   packet_length,
    input  logic [15:0]                   sequence_req,
    input  logic [63:0]                   arrival_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          popped,
    output logic [15:0]                   out_ref,
    output logic [15:0]                   out_sequence,
    output logic [63:0]                   out_time,
    output logic                          add_ignored,
    output logic [6:0]                    fill_count,
    output logic [63:0]                   fill_span_ns,
    output logic [31:0]                   received_count,
    output logic [31:0]                   dropped_count
);

    jrb_pkg::cmd_t    cmd;
    jrb_pkg::status_t status;

    // register writes never stall, so cfg_ready is tied high
    assign cfg_ready = 1'b1;

    jrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    jrb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .packet_ref     (packet_ref),
        .packet_length  (packet_length),
        .sequence_req   (sequence_req),
        .arrival_time   (arrival_time),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .popped         (popped),
        .out_ref        (out_ref),
        .out_sequence   (out_sequence),
        .out_time       (out_time),
        .add_ignored    (add_ignored),
        .fill_count     (fill_count),
        .fill_span_ns   (fill_span_ns),
        .received_count (received_count),
        .dropped_count  (dropped_count)
    );

endmodule
